/* design/char_lcd_bus_sequencer_defines.svh */
// Assertion macros for the character LCD bus sequencer.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked out of reset
`define LCDSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LCDSEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDSEQ_ASSERT(lbl, prop, msg)
`define LCDSEQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* design/lcdseq_pkg.sv */
// Shared types and constants of the character LCD bus sequencer.
// No dependencies.
`default_nettype none
package lcdseq_pkg;

  localparam int SHIFT_COLUMN = 16;
  localparam int INIT_WAIT_US = 500;
  localparam int COL_W        = $clog2(SHIFT_COLUMN + 2);
  localparam int WAIT_W       = 16;
  localparam int UNIT_W       = 3;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [WAIT_W-1:0] INIT_WAIT = WAIT_W'(INIT_WAIT_US);

  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] GOTO_FLAG      = 8'h80;
  localparam logic [7:0] CMD_LINE2_COL3 = GOTO_FLAG | (8'h40 + 8'h03);
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h18;

  localparam logic [0:0] CFG_BUS_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_CHAR_DELAY = 1'b1;

  typedef enum logic [1:0] {
    OP_PRINT   = 2'd0,
    OP_COMMAND = 2'd1,
    OP_GOTO    = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    JOB_CMD  = 2'd0,
    JOB_DATA = 2'd1,
    JOB_INIT = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       shift;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_beat_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       string_start;
  } in_t;

  typedef struct packed {
    logic              register_select;
    logic [7:0]        bus_value;
    logic [WAIT_W-1:0] wait_after;
    logic              last;
  } out_t;

endpackage
`default_nettype wire

/* design/lcdseq_front.sv */
// Front end: accepts requests, keeps the column count, classifies into jobs.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_front
  import lcdseq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_t       in_data,
  input  wire logic      q_full,
  output job_beat_t      push
);

  logic [COL_W-1:0] col_r, col_nxt, col_base;
  logic             accept;
  job_t             job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_base  = in_data.string_start ? '0 : col_r;
    col_nxt   = col_r;
    job.kind  = JOB_CMD;
    job.shift = 1'b0;
    job.value = in_data.byte_value;
    case (op_t'(in_data.operation))
      OP_PRINT: begin
        if (in_data.byte_value == NEWLINE_CHAR) begin
          job.value = CMD_LINE2_COL3;
          col_nxt   = '0;
        end else begin
          job.kind  = JOB_DATA;
          job.shift = (col_base > COL_W'(SHIFT_COLUMN));
          col_nxt   = (col_base < COL_W'(SHIFT_COLUMN + 1)) ? col_base + 1'b1 : col_base;
        end
      end
      OP_COMMAND: job.kind = JOB_CMD;
      OP_GOTO:    job.value = in_data.byte_value | GOTO_FLAG;
      OP_INIT:    job.kind = JOB_INIT;
      default:    job.kind = JOB_CMD;
    endcase
    if (!accept) begin
      col_nxt = col_r;
    end
  end

  assign push.valid = accept;
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/lcdseq_queue.sv */
// Short job queue between front and back end.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_queue
  import lcdseq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_beat_t push,
  input  wire logic      pop,
  output job_beat_t      head,
  output logic           full
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.job;
    end
  end

endmodule
`default_nettype wire

/* design/lcdseq_back.sv */
// Back end: expands the head job into bus transfers, one per cycle unless the receiver stalls.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_back
  import lcdseq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire job_beat_t         head,
  output logic                   pop,
  input  wire logic              bus_width_mode,
  input  wire logic [WAIT_W-1:0] char_delay,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data
);

  // one byte (or lone nibble) of a job
  typedef struct packed {
    logic              rs;
    logic [7:0]        value;
    logic              single;
    logic [WAIT_W-1:0] hold_us;
    logic              last;
  } unit_t;

  function automatic unit_t init_unit(input logic nib, input logic [UNIT_W-1:0] idx);
    unit_t u;
    u         = '0;
    u.hold_us = INIT_WAIT;
    case (idx)
      3'd0, 3'd1, 3'd2: begin
        u.value  = nib ? 8'h03 : 8'h30;
        u.single = 1'b1;
      end
      3'd3: begin
        u.value  = nib ? 8'h02 : 8'h3C;
        u.single = nib;
      end
      3'd4: u.value = nib ? 8'h2C : 8'h0F;
      3'd5: u.value = nib ? 8'h0F : 8'h01;
      3'd6: begin
        u.value = nib ? 8'h01 : 8'h06;
        if (!nib) begin
          u.hold_us = '0;
          u.last    = 1'b1;
        end
      end
      default: begin
        u.value   = 8'h06;
        u.hold_us = '0;
        u.last    = 1'b1;
      end
    endcase
    return u;
  endfunction

  logic [UNIT_W-1:0] idx_r, idx_nxt;
  logic              phase_r, phase_nxt;
  logic              out_valid_r;
  out_t              out_data_r;
  unit_t             unit;
  out_t              xfer;
  logic              two_phase;
  logic              load;

  always_comb begin
    unit = '0;
    case (head.job.kind)
      JOB_CMD: begin
        unit.value = head.job.value;
        unit.last  = 1'b1;
      end
      JOB_DATA: begin
        if (head.job.shift && idx_r == '0) begin
          unit.value = CMD_SHIFT_LEFT;
        end else begin
          unit.rs      = 1'b1;
          unit.value   = head.job.value;
          unit.hold_us = char_delay;
          unit.last    = 1'b1;
        end
      end
      JOB_INIT: unit = init_unit(bus_width_mode, idx_r);
      default:  unit.last = 1'b1;
    endcase

    two_phase            = bus_width_mode && !unit.single;
    xfer.register_select = unit.rs;
    if (!two_phase) begin
      xfer.bus_value  = unit.value;
      xfer.wait_after = unit.hold_us;
      xfer.last       = unit.last;
    end else if (!phase_r) begin
      xfer.bus_value  = {4'h0, unit.value[7:4]};
      xfer.wait_after = '0;
      xfer.last       = 1'b0;
    end else begin
      xfer.bus_value  = {4'h0, unit.value[3:0]};
      xfer.wait_after = unit.hold_us;
      xfer.last       = unit.last;
    end

    load      = head.valid && (!out_valid_r || out_ready);
    pop       = load && xfer.last;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    if (load) begin
      if (xfer.last) begin
        idx_nxt   = '0;
        phase_nxt = 1'b0;
      end else if (two_phase && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= xfer;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* design/char_lcd_bus_sequencer.sv */
// Top level of the character LCD bus sequencer: config registers and wiring.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_queue, lcdseq_back and the defines header.
//
// Usage:
//  - in_*: one request per beat (print, raw command, go-to address, initialize).
//  - out_*: one bus transfer per beat: register select, byte or nibble, the
//    wait to hold after the enable pulse, and last on the final transfer.
//  - cfg_*: write-only registers, index 0 bus width (1 = 4-bit), index 1 the
//    per-character delay. Write them only while the block is idle.
//  - A request gives 1 to 12 transfers (print with shift in 4-bit mode: 4,
//    initialize: 7 or 12); the back end issues one transfer per cycle while
//    the receiver does not stall.
//  - When idle, a request goes through the queue, then the output register.
//  - A 2-deep job queue sits between front and back end; requests are taken
//    while transfers wait to drain, until the queue is full.
//  - When the receiver stalls, the output register holds its beat and the back
//    end stops; the front keeps taking requests into the queue.
//  - Reset (synchronous) empties the queue, drops out_valid, clears the
//    column count and sets both config registers to zero.
`default_nettype none
`include "char_lcd_bus_sequencer_defines.svh"
module char_lcd_bus_sequencer
  import lcdseq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [WAIT_W-1:0] cfg_wdata
);

  logic              bus_width_mode_r;
  logic [WAIT_W-1:0] char_delay_r;
  job_beat_t         q_push;
  job_beat_t         q_head;
  logic              q_pop;
  logic              q_full;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_width_mode_r <= 1'b0;
      char_delay_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUS_WIDTH:  bus_width_mode_r <= cfg_wdata[0];
        CFG_CHAR_DELAY: char_delay_r     <= cfg_wdata;
        default:        bus_width_mode_r <= bus_width_mode_r;
      endcase
    end
  end

  lcdseq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push)
  );

  lcdseq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full)
  );

  lcdseq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .bus_width_mode (bus_width_mode_r),
    .char_delay     (char_delay_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // back end only retires a job it actually holds
  `LCDSEQ_ASSERT(a_pop_has_job, q_pop |-> q_head.valid, "job retired from empty queue")
  // final beat taken with nothing queued leaves the output idle
  `LCDSEQ_ASSERT(a_drain_idle, (out_valid && out_ready && out_data.last && !q_head.valid) |=> !out_valid, "output valid after drain")
  // reset drops the output
  `LCDSEQ_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule
`default_nettype wire

/* test/lcdseq_transfer_checker.sv */
`timescale 1ns / 1ps
// Transfer scoreboard for char_lcd_bus_sequencer. Snoops the request, transfer
// and register ports, predicts every bus transfer and compares it per field.
// Depends on lcdseq_pkg.
module lcdseq_transfer_checker
  import lcdseq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_t              out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [WAIT_W-1:0] cfg_wdata,
  output int unsigned       mismatches,
  output int unsigned       pending
);

  // power-on sequence bytes
  localparam logic [7:0] WAKE_8BIT     = 8'h30;
  localparam logic [7:0] FN_SET_8BIT   = 8'h3C;
  localparam logic [7:0] FN_SET_4BIT   = 8'h2C;
  localparam logic [7:0] DISPLAY_ON    = 8'h0F;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] GO_4BIT       = 4'h2;
  localparam int         MAX_BURST     = 12;

  out_t              expected_xfers[$];
  out_t              burst[MAX_BURST];
  int                burst_len;
  logic              nibble_mode;
  logic [WAIT_W-1:0] char_wait;
  logic [COL_W-1:0]  column;

  task automatic add_xfer(input logic rs, input logic [7:0] val,
                          input logic [WAIT_W-1:0] hold);
    burst[burst_len].register_select = rs;
    burst[burst_len].bus_value       = val;
    burst[burst_len].wait_after      = hold;
    burst[burst_len].last            = 1'b0;
    burst_len++;
  endtask

  // a byte is one transfer on the 8-bit bus, high then low nibble on 4-bit
  task automatic add_byte(input logic rs, input logic [7:0] b,
                          input logic [WAIT_W-1:0] hold);
    if (nibble_mode) begin
      add_xfer(rs, {4'h0, b[7:4]}, '0);
      add_xfer(rs, {4'h0, b[3:0]}, hold);
    end else begin
      add_xfer(rs, b, hold);
    end
  endtask

  task automatic predict_transfers(input in_t req);
    int i;
    burst_len = 0;
    case (op_t'(req.operation))
      OP_PRINT: begin
        if (req.string_start) column = '0;
        if (req.byte_value == NEWLINE_CHAR) begin
          add_byte(1'b0, CMD_LINE2_COL3, '0);
          column = '0;
        end else begin
          if (column > SHIFT_COLUMN) add_byte(1'b0, CMD_SHIFT_LEFT, '0);
          add_byte(1'b1, req.byte_value, char_wait);
          if (column <= SHIFT_COLUMN) column = column + 1'b1;
        end
      end
      OP_COMMAND: add_byte(1'b0, req.byte_value, '0);
      OP_GOTO:    add_byte(1'b0, req.byte_value | GOTO_FLAG, '0);
      OP_INIT: begin
        if (nibble_mode) begin
          repeat (3) add_xfer(1'b0, {4'h0, WAKE_NIBBLE}, INIT_WAIT);
          add_xfer(1'b0, {4'h0, GO_4BIT}, INIT_WAIT);
          add_byte(1'b0, FN_SET_4BIT, INIT_WAIT);
        end else begin
          repeat (3) add_byte(1'b0, WAKE_8BIT, INIT_WAIT);
          add_byte(1'b0, FN_SET_8BIT, INIT_WAIT);
        end
        add_byte(1'b0, DISPLAY_ON, INIT_WAIT);
        add_byte(1'b0, CLEAR_DISPLAY, INIT_WAIT);
        add_byte(1'b0, ENTRY_MODE, '0);
      end
      default: ;
    endcase
    burst[burst_len-1].last = 1'b1;
    for (i = 0; i < burst_len; i++) expected_xfers.push_back(burst[i]);
  endtask

  task automatic check_xfer(input out_t got, inout int unsigned bad);
    out_t want;
    if (expected_xfers.size() == 0) begin
      $error("transfer with nothing expected: rs=%0d bus=%02h wait=%0d last=%0d",
             got.register_select, got.bus_value, got.wait_after, got.last);
      bad++;
    end else begin
      want = expected_xfers.pop_front();
      if (got.register_select !== want.register_select) begin
        $error("register_select: expected %0d, got %0d",
               want.register_select, got.register_select);
        bad++;
      end
      if (got.bus_value !== want.bus_value) begin
        $error("bus_value: expected %02h, got %02h", want.bus_value, got.bus_value);
        bad++;
      end
      if (got.wait_after !== want.wait_after) begin
        $error("wait_after: expected %0d, got %0d", want.wait_after, got.wait_after);
        bad++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        bad++;
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    int unsigned bad;
    bad = 0;
    if (!rst_n) begin
      expected_xfers.delete();
      column      = '0;
      nibble_mode = 1'b0;
      char_wait   = '0;
      mismatches <= 0;
    end else begin
      // a transfer can never answer a request taken at the same edge
      if (out_valid && out_ready) check_xfer(out_data, bad);
      if (in_valid && in_ready) predict_transfers(in_data);
      if (cfg_we) begin
        if (cfg_index == CFG_BUS_WIDTH) nibble_mode = cfg_wdata[0];
        else                            char_wait   = cfg_wdata;
      end
      mismatches <= mismatches + bad;
    end
    pending <= expected_xfers.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Top of the char_lcd_bus_sequencer testbench: clock, reset, register set-up,
// request stimulus and receiver back-pressure; verdict from the checker.
// Depends on lcdseq_pkg, the design and lcdseq_transfer_checker.
module tb;
  import lcdseq_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 32;
  // idle wait after the final drain
  localparam int SETTLE_CYCLES = 24;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we;
  logic [0:0]        cfg_index;
  logic [WAIT_W-1:0] cfg_wdata;
  int unsigned       mismatches;
  int unsigned       pending;

  // calm: no request gaps and no receiver stalls
  bit                calm = 1'b0;
  int unsigned       stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_lcd_bus_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcdseq_transfer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Receiver: ready most of the time, with stall bursts in between.
  // A new burst may follow straight on from the last one.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One request beat. Valid stays high after the beat so a following call
  // carries straight on; a gap lowers it first.
  task automatic send(input op_t op, input logic [7:0] val, input logic opens);
    in_t req;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.operation    = op;
    req.byte_value   = val;
    req.string_start = opens;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Every request yields at least one transfer, so an empty scoreboard means
  // the block is idle. Valid drops and the clock advances first so the last beat is counted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic set_registers(input logic nibbles, input logic [WAIT_W-1:0] hold_us);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BUS_WIDTH;
    cfg_wdata <= WAIT_W'(nibbles);
    @(posedge clk);
    cfg_index <= CFG_CHAR_DELAY;
    cfg_wdata <= hold_us;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int         left;
    int         pick;
    int         len;
    int         nl_odds;
    int         k;
    int         p;
    logic [7:0] ch;
    logic       opens;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BUS_WIDTH;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // 8-bit bus, no character delay: the low extremes
    set_registers(1'b0, '0);

    // Directed: init (byte and string flag ignored), raw and go-to commands at
    // the byte extremes, go-to with bit 7 already set, a lone newline.
    send(OP_INIT, 8'hA5, 1'b1);
    send(OP_COMMAND, 8'h00, 1'b0);
    send(OP_COMMAND, 8'hFF, 1'b1);
    send(OP_GOTO, 8'h00, 1'b0);
    send(OP_GOTO, 8'hFF, 1'b0);
    send(OP_PRINT, NEWLINE_CHAR, 1'b0);
    // One long string: NUL and 0xFF print as data, the 18th character is the
    // first to need the shift-left, the 19th checks the count saturates.
    for (k = 0; k < 19; k++) begin
      ch = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(8'h40 + k);
      send(OP_PRINT, ch, k == 0);
    end
    // newline that also opens a string
    send(OP_PRINT, NEWLINE_CHAR, 1'b1);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0:       set_registers(1'b1, 16'hFFFF);
        1:       set_registers(1'b0, 16'($urandom));
        2:       set_registers(1'b1, '0);
        3:       set_registers(1'b0, 16'hFFFF);
        4:       set_registers(1'b1, 16'($urandom_range(1, 2000)));
        default: set_registers(1'($urandom), 16'($urandom));
      endcase
      // one quiet stretch mid-run, and the final phase runs flat out
      calm <= (p == 2 || p == RANDOM_PHASES - 1);

      left = PHASE_ITEMS;
      while (left > 0) begin
        pick = $urandom_range(0, 15);
        if (pick < 10) begin
          // Mostly well-formed strings with random content; a quarter run
          // past the shift column. Now and then a string carries on the
          // current line or restarts midway.
          len     = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 30)
                                                : $urandom_range(1, 12);
          nl_odds = (len > 16) ? 40 : 8;
          for (k = 0; k < len && left > 0; k++) begin
            ch    = ($urandom_range(1, nl_odds) == 1) ? NEWLINE_CHAR
                                                      : 8'($urandom_range(0, 255));
            opens = (k == 0) ? ($urandom_range(0, 5) != 0)
                             : ($urandom_range(0, 30) == 0);
            send(OP_PRINT, ch, opens);
            left--;
          end
        end else if (pick < 13) begin
          send(OP_COMMAND, 8'($urandom), 1'($urandom));
          left--;
        end else if (pick < 15) begin
          send(OP_GOTO, 8'($urandom), 1'($urandom));
          left--;
        end else begin
          send(OP_INIT, 8'($urandom), 1'($urandom));
          left--;
        end
      end
    end

    drain();
    // catch any stray transfer after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* char_lcd_bus_sequencer.f */
+incdir+design
design/lcdseq_pkg.sv
design/lcdseq_front.sv
design/lcdseq_queue.sv
design/lcdseq_back.sv
design/char_lcd_bus_sequencer.sv
test/lcdseq_transfer_checker.sv
test/tb.sv
